// ----- design/dtok_pkg.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer package
// Shared constants, codes, item and result types, and the set-match helper.
// ----------------------------------------------------------------------------
`default_nettype none

package dtok_pkg;

    localparam int TOKEN_MAX_DEF = 256;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [63:0] BLANK_SET_RST = 64'd168626464;
    localparam logic [63:0] DELIM_SET_RST = 64'd0;
    localparam logic [63:0] TERM_SET_RST  = 64'd34;
    localparam logic [8:0]  MAX_TOKEN_RST = 9'd256;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BLANK_SET = 2'd0;
    localparam logic [1:0] CFG_DELIM_SET = 2'd1;
    localparam logic [1:0] CFG_TERM_SET  = 2'd2;
    localparam logic [1:0] CFG_MAX_TOKEN = 2'd3;

    // Request codes; the fourth code is ignored.
    localparam logic [1:0] REQ_CHAR    = 2'd0;
    localparam logic [1:0] REQ_CAPTURE = 2'd1;
    localparam logic [1:0] REQ_FLUSH   = 2'd2;

    localparam logic [7:0]  CHAR_HASH = 8'h23;
    localparam logic [7:0]  CHAR_NL   = 8'h0A;
    localparam logic [15:0] LINE_MAX  = 16'hFFFF;
    localparam logic [15:0] LINE_ONE  = 16'd1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_COMMENT,
        MODE_CAPTURE
    } mode_t;

    typedef struct packed {
        logic blank;
        logic hash;
        logic delim;
        logic term;
        logic nl;
    } cls_t;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] ch;
        cls_t       cls;
    } item_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        tend;
        logic [15:0] line;
    } res_t;

    // A zero byte in a set is an unused slot and matches nothing.
    function automatic logic in_set(input logic [63:0] set, input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (set[8*i +: 8] != 8'd0 && set[8*i +: 8] == c)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- design/dtok_if.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer channel interfaces
// Valid/ready channels for input characters and for token results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtok_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] ch;

    modport source (output valid, output req_type, output ch, input ready);
    modport sink (input valid, input req_type, input ch, output ready);
endinterface

interface dtok_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        token_end;
    logic [15:0] token_line;

    modport source (output valid, output out_char, output token_end, output token_line,
                    input ready);
    modport sink (input valid, input out_char, input token_end, input token_line,
                  output ready);
endinterface

`default_nettype wire

// ----- design/delimiter_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer
// Splits a character stream into tokens of characters and end marks.
// ----------------------------------------------------------------------------
// The block takes one character beat per clock while its queue has room, and
// turns the stream into token beats: each result is either one token
// character or one end mark, and carries the line on which its token started.
// Blanks are dropped, a hash sign starts a comment that lasts to the newline,
// a delimiter is a one-character token, and other characters build a word
// that ends at a blank, a delimiter, a hash sign, a newline (kept as its last
// character) or when it reaches the buffer size minus one. A capture request
// makes the next token run up to and including a terminator or the newline,
// and a flush request closes whatever token is open. Throughput is set by the
// result port, which sends one beat per cycle while ready is high: an item
// with at most one result does not hold the lexer, one with two or three
// holds it until all but the last are taken. A four-entry queue between the
// classifier and the lexer absorbs those bursts, so the input side keeps
// taking characters while results wait to be taken. Input ready drops only
// when the queue is full. Configuration writes take effect at once and must
// be made by the user only while the block is idle, which is not enforced.
`default_nettype none

module delimiter_tokenizer_unit #(
    parameter int TOKEN_MAX   = dtok_pkg::TOKEN_MAX_DEF,
    parameter int QUEUE_DEPTH = dtok_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dtok_in_if.sink          chars,
    dtok_out_if.source       tokens,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int CCW = $clog2(TOKEN_MAX);

    // Classified items travel from the front part to the lexer through the queue.
    dtok_pkg::item_t front_item;
    dtok_pkg::item_t head_item;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;

    // Character limit per token, already clamped and reduced by one.
    logic [CCW-1:0]  lim;

    dtok_front #(
        .TOKEN_MAX (TOKEN_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (front_item),
        .lim       (lim)
    );

    dtok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    // The lexer takes the head item only when its result slots will be free,
    // so the state advances exactly once per item.
    dtok_back #(
        .TOKEN_MAX (TOKEN_MAX)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (head_item),
        .q_pop   (q_pop),
        .lim     (lim),
        .tokens  (tokens)
    );

endmodule

`default_nettype wire

// ----- design/dtok_queue.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer item queue
// Small register FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_queue #(
    parameter int DEPTH = dtok_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dtok_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 valid,
    output dtok_pkg::item_t      head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dtok_pkg::item_t mem_reg [DEPTH];
    logic [AW-1:0]   wptr_reg, wptr_next;
    logic [AW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/dtok_front.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer front part
// Holds the configuration registers, accepts characters and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_front #(
    parameter int TOKEN_MAX = dtok_pkg::TOKEN_MAX_DEF,
    localparam int CCW = $clog2(TOKEN_MAX)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dtok_in_if.sink          chars,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        q_full,
    output logic             q_push,
    output dtok_pkg::item_t  q_item,
    output logic [CCW-1:0]   lim
);

    localparam int EW = (CCW + 1 > 10) ? CCW + 1 : 10;

    logic [63:0]   blank_set_reg;
    logic [63:0]   delim_set_reg;
    logic [63:0]   term_set_reg;
    logic [8:0]    max_token_reg;
    logic [EW-1:0] mt_ext;
    logic [EW-1:0] mt_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_set_reg <= dtok_pkg::BLANK_SET_RST;
            delim_set_reg <= dtok_pkg::DELIM_SET_RST;
            term_set_reg  <= dtok_pkg::TERM_SET_RST;
            max_token_reg <= dtok_pkg::MAX_TOKEN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dtok_pkg::CFG_BLANK_SET: blank_set_reg <= cfg_data;
                dtok_pkg::CFG_DELIM_SET: delim_set_reg <= cfg_data;
                dtok_pkg::CFG_TERM_SET:  term_set_reg  <= cfg_data;
                dtok_pkg::CFG_MAX_TOKEN: max_token_reg <= cfg_data[8:0];
            endcase
        end
    end

    // Buffer size is clamped to the range two up to the built-in maximum.
    always_comb
    begin
        mt_ext = EW'(max_token_reg);
        priority if (mt_ext < EW'(2))
        begin
            mt_clamped = EW'(2);
        end
        else if (mt_ext > EW'(TOKEN_MAX))
        begin
            mt_clamped = EW'(TOKEN_MAX);
        end
        else
        begin
            mt_clamped = mt_ext;
        end
    end

    assign lim = CCW'(mt_clamped - EW'(1));

    assign chars.ready = !q_full;
    assign q_push      = chars.valid && !q_full;

    always_comb
    begin
        q_item.req       = chars.req_type;
        q_item.ch        = chars.ch;
        q_item.cls.blank = dtok_pkg::in_set(blank_set_reg, chars.ch);
        q_item.cls.hash  = (chars.ch == dtok_pkg::CHAR_HASH);
        q_item.cls.delim = dtok_pkg::in_set(delim_set_reg, chars.ch);
        q_item.cls.term  = dtok_pkg::in_set(term_set_reg, chars.ch);
        q_item.cls.nl    = (chars.ch == dtok_pkg::CHAR_NL);
    end

endmodule

`default_nettype wire

// ----- design/dtok_back.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer back part
// Runs the lexer state machine and sends the results of each item in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_back #(
    parameter int TOKEN_MAX = dtok_pkg::TOKEN_MAX_DEF,
    localparam int CCW = $clog2(TOKEN_MAX)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire dtok_pkg::item_t q_item,
    output logic                 q_pop,
    input  wire logic [CCW-1:0]  lim,
    dtok_out_if.source           tokens
);

    dtok_pkg::mode_t mode_reg, mode_next;
    logic [CCW-1:0]  cc_reg, cc_next;
    logic [15:0]     line_reg, line_next;
    logic [15:0]     start_reg, start_next;
    dtok_pkg::res_t  pend_reg [3];
    dtok_pkg::res_t  pend_next [3];
    logic [1:0]      rem_reg, rem_next;

    dtok_pkg::res_t  r [3];
    logic [1:0]      k;
    logic [CCW-1:0]  cc_inc;
    logic            can_load;
    logic            out_take;

    function automatic dtok_pkg::res_t mk(input logic [7:0] c, input logic e,
                                          input logic [15:0] l);
        dtok_pkg::res_t x;
        x.ch   = c;
        x.tend = e;
        x.line = l;
        return x;
    endfunction

    assign tokens.valid      = (rem_reg != 2'd0);
    assign tokens.out_char   = pend_reg[0].ch;
    assign tokens.token_end  = pend_reg[0].tend;
    assign tokens.token_line = pend_reg[0].line;

    assign out_take = tokens.valid && tokens.ready;
    assign can_load = (rem_reg == 2'd0) || (rem_reg == 2'd1 && tokens.ready);
    assign q_pop    = q_valid && can_load;
    assign cc_inc   = cc_reg + 1'b1;

    // Lexer next state and the results of the item at the head of the queue.
    always_comb
    begin
        mode_next  = mode_reg;
        cc_next    = cc_reg;
        line_next  = line_reg;
        start_next = start_reg;
        k          = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            r[i] = '0;
        end
        if (q_pop)
        begin
            unique case (q_item.req)
                dtok_pkg::REQ_CHAR:
                begin
                    unique case (mode_reg)
                        dtok_pkg::MODE_IDLE:
                        begin
                            priority if (q_item.cls.blank)
                            begin
                            end
                            else if (q_item.cls.hash)
                            begin
                                mode_next = dtok_pkg::MODE_COMMENT;
                            end
                            else if (q_item.cls.delim)
                            begin
                                start_next = line_reg;
                                r[k] = mk(q_item.ch, 1'b0, line_reg);
                                k = k + 2'd1;
                                r[k] = mk(8'd0, 1'b1, line_reg);
                                k = k + 2'd1;
                            end
                            else
                            begin
                                start_next = line_reg;
                                r[k] = mk(q_item.ch, 1'b0, line_reg);
                                k = k + 2'd1;
                                if (lim == CCW'(1) || q_item.cls.nl)
                                begin
                                    r[k] = mk(8'd0, 1'b1, line_reg);
                                    k = k + 2'd1;
                                end
                                else
                                begin
                                    mode_next = dtok_pkg::MODE_WORD;
                                    cc_next   = CCW'(1);
                                end
                            end
                        end
                        dtok_pkg::MODE_WORD:
                        begin
                            priority if (q_item.cls.hash)
                            begin
                                r[k] = mk(8'd0, 1'b1, start_reg);
                                k = k + 2'd1;
                                mode_next = dtok_pkg::MODE_COMMENT;
                                cc_next   = '0;
                            end
                            else if (q_item.cls.delim || q_item.cls.blank)
                            begin
                                r[k] = mk(8'd0, 1'b1, start_reg);
                                k = k + 2'd1;
                                mode_next = dtok_pkg::MODE_IDLE;
                                cc_next   = '0;
                                // A delimiter that is not also a blank is its own token.
                                if (!q_item.cls.blank)
                                begin
                                    start_next = line_reg;
                                    r[k] = mk(q_item.ch, 1'b0, line_reg);
                                    k = k + 2'd1;
                                    r[k] = mk(8'd0, 1'b1, line_reg);
                                    k = k + 2'd1;
                                end
                            end
                            else
                            begin
                                r[k] = mk(q_item.ch, 1'b0, start_reg);
                                k = k + 2'd1;
                                cc_next = cc_inc;
                                if (cc_inc >= lim || q_item.cls.nl)
                                begin
                                    r[k] = mk(8'd0, 1'b1, start_reg);
                                    k = k + 2'd1;
                                    mode_next = dtok_pkg::MODE_IDLE;
                                    cc_next   = '0;
                                end
                            end
                        end
                        dtok_pkg::MODE_CAPTURE:
                        begin
                            r[k] = mk(q_item.ch, 1'b0, start_reg);
                            k = k + 2'd1;
                            cc_next = cc_inc;
                            if (q_item.cls.term || q_item.cls.nl || cc_inc >= lim)
                            begin
                                r[k] = mk(8'd0, 1'b1, start_reg);
                                k = k + 2'd1;
                                mode_next = dtok_pkg::MODE_IDLE;
                                cc_next   = '0;
                            end
                        end
                        dtok_pkg::MODE_COMMENT:
                        begin
                            if (q_item.cls.nl)
                            begin
                                mode_next = dtok_pkg::MODE_IDLE;
                            end
                        end
                    endcase
                    if (q_item.cls.nl && line_reg != dtok_pkg::LINE_MAX)
                    begin
                        line_next = line_reg + 16'd1;
                    end
                end
                dtok_pkg::REQ_CAPTURE:
                begin
                    if ((mode_reg == dtok_pkg::MODE_WORD || mode_reg == dtok_pkg::MODE_CAPTURE)
                        && cc_reg != '0)
                    begin
                        r[k] = mk(8'd0, 1'b1, start_reg);
                        k = k + 2'd1;
                    end
                    mode_next  = dtok_pkg::MODE_CAPTURE;
                    cc_next    = '0;
                    start_next = line_reg;
                end
                dtok_pkg::REQ_FLUSH:
                begin
                    if ((mode_reg == dtok_pkg::MODE_WORD || mode_reg == dtok_pkg::MODE_CAPTURE)
                        && cc_reg != '0)
                    begin
                        r[k] = mk(8'd0, 1'b1, start_reg);
                        k = k + 2'd1;
                    end
                    mode_next = dtok_pkg::MODE_IDLE;
                    cc_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pending results shift toward slot zero as each beat is taken.
    always_comb
    begin
        rem_next     = rem_reg;
        pend_next[0] = pend_reg[0];
        pend_next[1] = pend_reg[1];
        pend_next[2] = pend_reg[2];
        if (q_pop)
        begin
            rem_next     = k;
            pend_next[0] = r[0];
            pend_next[1] = r[1];
            pend_next[2] = r[2];
        end
        else if (out_take)
        begin
            rem_next     = rem_reg - 2'd1;
            pend_next[0] = pend_reg[1];
            pend_next[1] = pend_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dtok_pkg::MODE_IDLE;
            cc_reg    <= '0;
            line_reg  <= dtok_pkg::LINE_ONE;
            start_reg <= dtok_pkg::LINE_ONE;
            rem_reg   <= 2'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            cc_reg    <= cc_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg[0] <= pend_next[0];
        pend_reg[1] <= pend_next[1];
        pend_reg[2] <= pend_next[2];
    end

endmodule

`default_nettype wire

// ----- design/dtok_checker.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  out_char,
    input wire logic        token_end,
    input wire logic [15:0] token_line
);

    // A stalled result beat stays offered and unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char)
        && $stable(token_end) && $stable(token_line))
        else $error("result beat changed while stalled");

    // An end mark carries no character.
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_end |-> out_char == 8'd0)
        else $error("end mark with a character");

    // Line numbers start at one and saturate, so zero never appears.
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_line != 16'd0)
        else $error("token line is zero");

    // Every token holds at least one character, so two end marks never follow.
    a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && token_end ##1 out_valid && out_ready |-> !token_end)
        else $error("empty token");

endmodule

bind delimiter_tokenizer_unit dtok_checker u_dtok_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (tokens.valid),
    .out_ready  (tokens.ready),
    .out_char   (tokens.out_char),
    .token_end  (tokens.token_end),
    .token_line (tokens.token_line)
);

`default_nettype wire

// ----- sim/dtok_token_checker.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer token checker
// Watches the character, token and register ports, predicts each token beat
// and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_token_checker #(
    parameter int TOKEN_MAX = dtok_pkg::TOKEN_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  in_req,
    input  wire logic [7:0]  in_ch,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  out_char,
    input  wire logic        out_end,
    input  wire logic [15:0] out_line,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output int               mismatches,
    output int               beats_waiting,
    output int               beats_checked
);

    import dtok_pkg::*;

    logic [63:0]  blanks;
    logic [63:0]  delims;
    logic [63:0]  terms;
    logic [8:0]   size_reg;
    mode_t        mode;
    int unsigned  run_len;
    logic [15:0]  cur_line;
    logic [15:0]  tok_line;
    res_t         expected_beats[$];

    function automatic bit holds(input logic [63:0] set, input logic [7:0] c);
        bit found;
        found = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (set[8*k +: 8] != 8'd0 && set[8*k +: 8] == c)
            begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // Longest token in characters, with the size register clamped to its usable range.
    function automatic int unsigned word_cap();
        int unsigned s;
        s = size_reg;
        if (s < 2)
        begin
            s = 2;
        end
        if (s > TOKEN_MAX)
        begin
            s = TOKEN_MAX;
        end
        return s - 1;
    endfunction

    task automatic emit(input logic [7:0] c, input logic mark);
        res_t b;
        b.ch   = c;
        b.tend = mark;
        b.line = tok_line;
        expected_beats.push_back(b);
    endtask

    task automatic close_token();
        emit(8'd0, 1'b1);
        mode    = MODE_IDLE;
        run_len = 0;
    endtask

    task automatic start_token(input logic [7:0] c);
        if (holds(blanks, c))
        begin
            return;
        end
        if (c == CHAR_HASH)
        begin
            mode = MODE_COMMENT;
            return;
        end
        tok_line = cur_line;
        if (holds(delims, c))
        begin
            emit(c, 1'b0);
            emit(8'd0, 1'b1);
            return;
        end
        emit(c, 1'b0);
        run_len = 1;
        if (run_len >= word_cap() || c == CHAR_NL)
        begin
            close_token();
        end
        else
        begin
            mode = MODE_WORD;
        end
    endtask

    task automatic extend_word(input logic [7:0] c);
        if (c == CHAR_HASH)
        begin
            emit(8'd0, 1'b1);
            mode    = MODE_COMMENT;
            run_len = 0;
        end
        else if (holds(delims, c) || holds(blanks, c))
        begin
            close_token();
            start_token(c);
        end
        else
        begin
            emit(c, 1'b0);
            run_len++;
            if (run_len >= word_cap() || c == CHAR_NL)
            begin
                close_token();
            end
        end
    endtask

    task automatic extend_capture(input logic [7:0] c);
        emit(c, 1'b0);
        run_len++;
        if (holds(terms, c) || c == CHAR_NL || run_len >= word_cap())
        begin
            close_token();
        end
    endtask

    task automatic lex_item(input logic [1:0] req, input logic [7:0] c);
        case (req)
            REQ_CHAR:
            begin
                case (mode)
                    MODE_IDLE:    start_token(c);
                    MODE_WORD:    extend_word(c);
                    MODE_CAPTURE: extend_capture(c);
                    default:
                    begin
                        if (c == CHAR_NL)
                        begin
                            mode = MODE_IDLE;
                        end
                    end
                endcase
                if (c == CHAR_NL && cur_line != LINE_MAX)
                begin
                    cur_line++;
                end
            end
            REQ_CAPTURE, REQ_FLUSH:
            begin
                if ((mode == MODE_WORD || mode == MODE_CAPTURE) && run_len > 0)
                begin
                    emit(8'd0, 1'b1);
                end
                run_len = 0;
                if (req == REQ_CAPTURE)
                begin
                    mode     = MODE_CAPTURE;
                    tok_line = cur_line;
                end
                else
                begin
                    mode = MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blanks        = BLANK_SET_RST;
            delims        = DELIM_SET_RST;
            terms         = TERM_SET_RST;
            size_reg      = MAX_TOKEN_RST;
            mode          = MODE_IDLE;
            run_len       = 0;
            cur_line      = LINE_ONE;
            tok_line      = LINE_ONE;
            mismatches    = 0;
            beats_checked = 0;
            expected_beats.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_BLANK_SET: blanks   = cfg_data;
                    CFG_DELIM_SET: delims   = cfg_data;
                    CFG_TERM_SET:  terms    = cfg_data;
                    CFG_MAX_TOKEN: size_reg = cfg_data[8:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
            begin
                lex_item(in_req, in_ch);
            end
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Unexpected token beat: char %h end %b line %0d",
                                 out_char, out_end, out_line);
                    end
                end
                else
                begin
                    res_t want;
                    want = expected_beats.pop_front();
                    beats_checked++;
                    if (want.ch !== out_char || want.tend !== out_end ||
                        want.line !== out_line)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Token beat %0d: expected char %h end %b line %0d, got char %h end %b line %0d",
                                     beats_checked, want.ch, want.tend, want.line,
                                     out_char, out_end, out_line);
                        end
                    end
                end
            end
        end
        beats_waiting = expected_beats.size();
    end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer testbench
// Feeds character and request beats through register settings of every kind
// and lets the token checker judge each token beat the block sends back.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import dtok_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 7;
    // A safe bound: far above the slowest legal run, even when every item
    // makes three beats and each beat meets the longest result stall.
    localparam int LIMIT_CYCLES  = 800000;
    // Items that make no token beat can still sit in the block's queue when
    // the last expected beat arrives, so settle this long before a write.
    localparam int SETTLE_CYCLES = QUEUE_DEPTH + 6;
    // The fourth request code, which the block must ignore.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    dtok_in_if  chars_if ();
    dtok_out_if tokens_if ();

    int mismatches;
    int beats_waiting;
    int beats_checked;

    // Stimulus-side copy of the current register settings, used only to pick
    // characters that exercise the sets.
    logic [63:0] cur_blank;
    logic [63:0] cur_delim;
    logic [63:0] cur_term;
    logic [8:0]  cur_size;

    bit steady;          // when set, neither side idles
    int beats_sent;      // accepted beats, the ignored request code excluded
    int settings_used;
    int stall_left;

    delimiter_tokenizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .tokens    (tokens_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dtok_token_checker token_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (chars_if.valid),
        .in_ready      (chars_if.ready),
        .in_req        (chars_if.req_type),
        .in_ch         (chars_if.ch),
        .out_valid     (tokens_if.valid),
        .out_ready     (tokens_if.ready),
        .out_char      (tokens_if.out_char),
        .out_end       (tokens_if.token_end),
        .out_line      (tokens_if.token_line),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .beats_waiting (beats_waiting),
        .beats_checked (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Idle lengths: most pauses fall in the shortest band, some in a longer one,
    // and a small share is long enough to fill the block's queue.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(25, 60);
    endfunction

    function automatic int gap_len();
        if (steady || $urandom_range(0, 99) < 55)
        begin
            return 0;
        end
        return pause_len();
    endfunction

    // Result side: ready drops now and then for a random stretch, and stays
    // high throughout while the run is in a steady stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            tokens_if.ready <= 1'b0;
        end
        else if (steady)
        begin
            stall_left = 0;
            tokens_if.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            tokens_if.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left = pause_len() - 1;
            tokens_if.ready <= 1'b0;
        end
        else
        begin
            tokens_if.ready <= 1'b1;
        end
    end

    // Offers one beat and waits for its handshake. Valid stays high when the
    // next beat follows at once, so it is never lowered and raised in one step.
    task automatic send_beat(input logic [1:0] req, input logic [7:0] c);
        int gap;
        chars_if.valid    <= 1'b1;
        chars_if.req_type <= req;
        chars_if.ch       <= c;
        do @(posedge clk); while (!chars_if.ready);
        if (req != REQ_UNUSED)
        begin
            beats_sent++;
        end
        gap = gap_len();
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every predicted token beat has been
    // seen, then lets items without results leave the block. The checker's
    // counters are read on the falling edge, away from its updates.
    task automatic drain();
        chars_if.valid <= 1'b0;
        do @(negedge clk); while (beats_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers back to back; only called while the block is
    // idle, right after reset or after a drain.
    task automatic apply_settings(input logic [63:0] blanks, input logic [63:0] delims,
                                  input logic [63:0] terms, input logic [8:0] size);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BLANK_SET;
        cfg_data  <= blanks;
        @(posedge clk);
        cfg_index <= CFG_DELIM_SET;
        cfg_data  <= delims;
        @(posedge clk);
        cfg_index <= CFG_TERM_SET;
        cfg_data  <= terms;
        @(posedge clk);
        cfg_index <= CFG_MAX_TOKEN;
        cfg_data  <= {55'd0, size};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_blank = blanks;
        cur_delim = delims;
        cur_term  = terms;
        cur_size  = size;
        settings_used++;
    endtask

    // A random member of a set, or the fallback when the set is empty.
    function automatic logic [7:0] pick_from(input logic [63:0] set,
                                             input logic [7:0] fallback);
        logic [7:0] slots[$];
        for (int k = 0; k < 8; k++)
        begin
            if (set[8*k +: 8] != 8'd0)
            begin
                slots.push_back(set[8*k +: 8]);
            end
        end
        if (slots.size() == 0)
        begin
            return fallback;
        end
        return slots[$urandom_range(0, slots.size() - 1)];
    endfunction

    // Mostly letters; now and then any byte, which may well be special.
    function automatic logic [7:0] word_byte();
        if ($urandom_range(0, 99) < 80)
        begin
            return 8'($urandom_range(8'h61, 8'h7A));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Random text: mostly well-formed words, blanks, delimiters, comments
    // and captures, with stray requests and raw bytes mixed in as noise.
    task automatic send_text(input int budget);
        int stop;
        int r;
        int n;
        int cap;
        stop = beats_sent + budget;
        while (beats_sent < stop)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                steady <= ~steady;
            end
            r = $urandom_range(0, 99);
            if (r < 32)
            begin
                // Words sometimes run past the length limit when it is small.
                cap = (cur_size < 2) ? 1 : ((cur_size > 256) ? 255 : cur_size - 1);
                cap = (cap + 2 > 12) ? 12 : cap + 2;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cap)
                                                : $urandom_range(1, 6);
                repeat (n) send_beat(REQ_CHAR, word_byte());
            end
            else if (r < 47)
            begin
                send_beat(REQ_CHAR, pick_from(cur_blank, 8'h20));
            end
            else if (r < 57)
            begin
                send_beat(REQ_CHAR, pick_from(cur_delim, 8'h2C));
            end
            else if (r < 65)
            begin
                send_beat(REQ_CHAR, CHAR_HASH);
                repeat ($urandom_range(0, 5)) send_beat(REQ_CHAR, 8'($urandom_range(0, 255)));
                send_beat(REQ_CHAR, CHAR_NL);
            end
            else if (r < 75)
            begin
                send_beat(REQ_CAPTURE, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 6)) send_beat(REQ_CHAR, word_byte());
                n = $urandom_range(0, 9);
                if (n < 7)
                begin
                    send_beat(REQ_CHAR, pick_from(cur_term, CHAR_NL));
                end
                else if (n < 9)
                begin
                    send_beat(REQ_CHAR, CHAR_NL);
                end
            end
            else if (r < 83)
            begin
                send_beat(REQ_CHAR, CHAR_NL);
            end
            else if (r < 87)
            begin
                send_beat(REQ_FLUSH, 8'($urandom_range(0, 255)));
            end
            else if (r < 89)
            begin
                send_beat(REQ_UNUSED, 8'($urandom_range(0, 255)));
            end
            else if (r < 92)
            begin
                // A capture request landing in whatever state the text left.
                send_beat(REQ_CAPTURE, 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_beat(REQ_CHAR, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        chars_if.valid    <= 1'b0;
        chars_if.req_type <= REQ_CHAR;
        chars_if.ch       <= 8'd0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= CFG_BLANK_SET;
        cfg_data          <= 64'd0;
        steady            <= 1'b0;
        cur_blank          = BLANK_SET_RST;
        cur_delim          = DELIM_SET_RST;
        cur_term           = TERM_SET_RST;
        cur_size           = MAX_TOKEN_RST;
        beats_sent         = 0;
        settings_used      = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: blanks are space, tab, carriage return and newline,
        // no delimiters, and the double quote ends a capture.
        send_beat(REQ_CHAR, "a");
        send_beat(REQ_CHAR, "b");
        send_beat(REQ_CHAR, " ");
        // A zero byte belongs to no set, so it is an ordinary word character.
        send_beat(REQ_CHAR, 8'h00);
        send_beat(REQ_CHAR, 8'hFF);
        // A hash sign ends the word and opens a comment.
        send_beat(REQ_CHAR, CHAR_HASH);
        send_beat(REQ_CHAR, "x");
        // Capture inside a comment drops the rest of the comment.
        send_beat(REQ_CAPTURE, 8'h00);
        send_beat(REQ_CHAR, "q");
        send_beat(REQ_CHAR, 8'h22);
        // Capture inside a word closes the word first.
        send_beat(REQ_CHAR, "w");
        send_beat(REQ_CAPTURE, 8'hFF);
        send_beat(REQ_CHAR, "z");
        // Capture inside a running capture closes it and starts another,
        // which the flush then drops since it is still empty.
        send_beat(REQ_CAPTURE, 8'h00);
        send_beat(REQ_FLUSH, 8'h00);
        send_beat(REQ_CHAR, "k");
        send_beat(REQ_FLUSH, 8'hFF);
        send_beat(REQ_UNUSED, 8'h5A);
        send_beat(REQ_CHAR, CHAR_NL);
        drain();

        // Newline no longer blank, comma and semicolon delimit, and tokens
        // hold at most two characters.
        apply_settings(64'h0920, 64'h3B2C, 64'h29, 9'd3);
        send_beat(REQ_CHAR, ",");
        send_beat(REQ_CHAR, "a");
        send_beat(REQ_CHAR, "b");
        send_beat(REQ_CHAR, "c");
        send_beat(REQ_CHAR, CHAR_NL);
        // A newline on its own becomes a one-character word.
        send_beat(REQ_CHAR, CHAR_NL);
        // A delimiter right after a word gives three beats from one item.
        send_beat(REQ_CHAR, "a");
        send_beat(REQ_CHAR, ",");
        drain();

        // Random sets of every bit pattern and short token limits.
        apply_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       9'($urandom_range(2, 20)));
        send_text(50);
        drain();

        // Size register at zero acts as two; empty delimiter and terminator
        // sets, and a blank set whose every slot holds the top byte value.
        apply_settings(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 9'd0);
        send_text(30);
        drain();

        // Size register at its top value is clamped to the buffer size, so a
        // long word is split after 255 characters.
        apply_settings(BLANK_SET_RST, {$urandom, $urandom}, {$urandom, $urandom}, 9'h1FF);
        for (int i = 0; i < 256; i++)
        begin
            send_beat(REQ_CHAR, 8'h61 + 8'(i % 26));
        end
        send_beat(REQ_CHAR, " ");
        send_text(20);
        drain();

        @(negedge clk);
        $display("Run covered %0d character and request beats under %0d register settings,",
                 beats_sent, settings_used);
        $display("including the length clamp at both ends; %0d token beats were compared.",
                 beats_checked);
        if (mismatches == 0 && beats_waiting == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d token beats still expected.", beats_waiting);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/dtok_pkg.sv
design/dtok_if.sv
design/dtok_queue.sv
design/dtok_front.sv
design/dtok_back.sv
design/delimiter_tokenizer_unit.sv
design/dtok_checker.sv
sim/dtok_token_checker.sv
sim/testbench.sv
